// File: design/gdem_pkg.sv
`default_nettype none

package gdem_pkg;

    // Axis shaping constants.
    localparam int unsigned DZ_LIMIT   = 7849;
    localparam int unsigned DZ_FULL    = 32767;
    localparam int unsigned DZ_SPAN    = DZ_FULL - DZ_LIMIT;
    localparam int unsigned ROUND_BIAS = DZ_SPAN / 2;

    // The quotient of a 30-bit value by DZ_SPAN is taken as a multiply by a rounded-up
    // reciprocal and a shift. The shift is 30 + ceil(log2(DZ_SPAN)), which keeps it exact.
    localparam int unsigned DIV_SHIFT = 45;
    localparam logic [63:0] DIV_MAGIC_W =
        ((64'd1 << DIV_SHIFT) + 64'(DZ_SPAN) - 64'd1) / 64'(DZ_SPAN);
    localparam logic [30:0] DIV_MAGIC = DIV_MAGIC_W[30:0];

    // Configuration register map.
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam logic        IDX_SHIELD   = 1'b0;
    localparam logic [7:0]  SHIELD_RESET = 8'd128;

    // Logical button positions in the held mask.
    localparam int unsigned BTN_ATTACK  = 0;
    localparam int unsigned BTN_SPECIAL = 1;
    localparam int unsigned BTN_JUMP    = 2;
    localparam int unsigned BTN_SHIELD  = 3;
    localparam int unsigned BTN_GRAB    = 4;
    localparam int unsigned BTN_START   = 5;
    localparam int unsigned BTN_BACK    = 6;
    localparam int unsigned BTN_UP      = 7;
    localparam int unsigned BTN_DOWN    = 8;
    localparam int unsigned BTN_LEFT    = 9;
    localparam int unsigned BTN_RIGHT   = 10;
    localparam int unsigned NUM_BTN     = 11;

    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_pull;
        logic [7:0]         right_pull;
        logic [15:0]        button_word;
    } sample_t;

    typedef struct packed {
        logic signed [15:0]   main_x;
        logic signed [15:0]   main_y;
        logic signed [15:0]   aux_x;
        logic signed [15:0]   aux_y;
        logic [7:0]           left_level;
        logic [7:0]           right_level;
        logic [NUM_BTN-1:0]   held_bits;
        logic [NUM_BTN-1:0]   pressed_bits;
        logic [NUM_BTN-1:0]   released_bits;
    } mapped_t;

    // Deadzone and rescale of one axis: zero inside the deadzone, otherwise
    // sign * min(round((mag - DZ_LIMIT) * DZ_FULL / DZ_SPAN), DZ_FULL).
    function automatic logic signed [15:0] shape_axis(input logic signed [15:0] raw);
        logic        neg;
        logic [16:0] mag;
        logic [14:0] excess;
        logic [29:0] numer;
        logic [60:0] prod;
        logic [15:0] quot;
        logic [15:0] sat;
        neg    = raw[15];
        mag    = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        excess = 15'(mag - 17'(DZ_LIMIT));
        // excess * DZ_FULL is excess * 2^15 - excess; the bias makes the quotient round.
        numer = {excess, 15'd0} - {15'd0, excess} + 30'(ROUND_BIAS);
        prod  = {31'd0, numer} * {30'd0, DIV_MAGIC};
        quot  = prod[60:45];
        sat   = (quot > 16'(DZ_FULL)) ? 16'(DZ_FULL) : quot;
        if (mag <= 17'(DZ_LIMIT))
        begin
            return 16'sd0;
        end
        return neg ? $signed(16'd0 - sat) : $signed(sat);
    endfunction

endpackage

`default_nettype wire

// File: design/gamepad_deadzone_edge_mapper.sv
// An accepted sample waits in the input stage register until the output register is free.
// One sample per cycle while out_stall is low; the stick rescale is a constant multiply
// per axis between the input stage register and the output register.
// Reset clears the pipeline valid flags, the previous held mask and the first-sample flag,
// and sets the shield trigger level to 128; the first sample reports every held bit as pressed.
`default_nettype none

module gamepad_deadzone_edge_mapper
    import gdem_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sample_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output mapped_t                    out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [7:0]         shield_level_reg;
    logic               s1_valid_reg;
    sample_t            s1_data_reg;
    logic               out_valid_reg;
    mapped_t            out_data_reg;
    logic [NUM_BTN-1:0] last_held_reg;
    logic [NUM_BTN-1:0] last_held_next;
    logic               seen_first_reg;
    logic               seen_first_next;

    logic               in_accept;
    logic               s1_advance;
    logic               cfg_write;
    logic [15:0]        btn;
    logic               shield_on;
    logic [NUM_BTN-1:0] held;
    logic [NUM_BTN-1:0] pressed;
    logic [NUM_BTN-1:0] released;
    mapped_t            result;

    // Configuration port: always ready, one register, selected when paddr[2] is zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == IDX_SHIELD);
    assign prdata    = (paddr[2] == IDX_SHIELD) ? {24'd0, shield_level_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shield_level_reg <= SHIELD_RESET;
        end
        else if (cfg_write)
        begin
            shield_level_reg <= pwdata[7:0];
        end
    end

    // Pipeline flow control: the input stage moves on whenever the output register is free.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= result;
        end
    end

    // Logical button mapping from the raw button word and trigger levels.
    assign btn       = s1_data_reg.button_word;
    assign shield_on = (btn[9:8] != 2'b00)
                    || (s1_data_reg.left_pull >= shield_level_reg)
                    || (s1_data_reg.right_pull >= shield_level_reg);

    always_comb
    begin
        held              = '0;
        held[BTN_ATTACK]  = btn[12];
        held[BTN_SPECIAL] = btn[13];
        held[BTN_JUMP]    = btn[14] || btn[15];
        held[BTN_SHIELD]  = shield_on;
        held[BTN_GRAB]    = btn[6] || btn[7];
        held[BTN_START]   = btn[4];
        held[BTN_BACK]    = btn[5];
        held[BTN_UP]      = btn[0];
        held[BTN_DOWN]    = btn[1];
        held[BTN_LEFT]    = btn[2];
        held[BTN_RIGHT]   = btn[3];
    end

    // Edge detection against the previous sample; before any sample all held bits are new.
    assign pressed  = held & (seen_first_reg ? ~last_held_reg : {NUM_BTN{1'b1}});
    assign released = last_held_reg & ~held;

    always_comb
    begin
        last_held_next  = last_held_reg;
        seen_first_next = seen_first_reg;
        if (s1_advance)
        begin
            last_held_next  = held;
            seen_first_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_held_reg  <= '0;
            seen_first_reg <= 1'b0;
        end
        else
        begin
            last_held_reg  <= last_held_next;
            seen_first_reg <= seen_first_next;
        end
    end

    // Result assembly: deadzoned axes, raw triggers and button masks.
    always_comb
    begin
        result.main_x        = shape_axis(s1_data_reg.left_x);
        result.main_y        = shape_axis(s1_data_reg.left_y);
        result.aux_x         = shape_axis(s1_data_reg.right_x);
        result.aux_y         = shape_axis(s1_data_reg.right_y);
        result.left_level    = s1_data_reg.left_pull;
        result.right_level   = s1_data_reg.right_pull;
        result.held_bits     = held;
        result.pressed_bits  = pressed;
        result.released_bits = released;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A button cannot be pressed and released in the same sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.pressed_bits & out_data_reg.released_bits) == '0))
        else $error("pressed and released masks overlap");

    // Pressed buttons are held, released buttons are not.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_data_reg.pressed_bits & ~out_data_reg.held_bits) == '0)
                        && ((out_data_reg.released_bits & out_data_reg.held_bits) == '0)))
        else $error("edge masks disagree with held mask");

    // The saturated axes never reach the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.main_x != 16'sh8000)
                        && (out_data_reg.main_y != 16'sh8000)
                        && (out_data_reg.aux_x != 16'sh8000)
                        && (out_data_reg.aux_y != 16'sh8000)))
        else $error("axis output not saturated");

    // Once a sample has gone to the output stage, the first-sample flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> (seen_first_reg && out_valid_reg))
        else $error("first-sample flag or output valid missing after stage advance");
`endif

endmodule

`default_nettype wire
